// ===== hdl/okl_pkg.sv =====
// Shared types and codes for the ordered key list engine.
`timescale 1ns / 1ps

package okl_pkg;

	// Port widths, fixed by the interface
	localparam int OP_W     = 3;
	localparam int KEY_W    = 32;
	localparam int OFS_W    = 5;
	localparam int ST_W     = 3;
	localparam int POS_W    = 5;
	localparam int CNT_OUT_W = 5;

	// Default sizing
	localparam int DEF_CAPACITY = 16;
	localparam int DEF_KEY_BITS = 32;

	// Cell index bus wide enough for the largest supported capacity (256)
	localparam int IDX_MAX_W = 8;

	// Opcodes
	localparam logic [OP_W-1:0] OP_INS_OFS = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_TOP = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_BOT = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_OFS = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_KEY = 3'd4;
	localparam logic [OP_W-1:0] OP_FIND    = 3'd5;
	localparam logic [OP_W-1:0] OP_MTF     = 3'd6;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_DUP     = 3'd1;
	localparam logic [ST_W-1:0] ST_RANGE   = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
	localparam logic [ST_W-1:0] ST_MISSING = 3'd4;

	// Per-cell update mode
	typedef enum logic [1:0] {
		CM_HOLD,
		CM_INS,   // cell lo takes the new key, cells in (lo, hi] take the left neighbor
		CM_DEL    // cells at and above lo take the right neighbor
	} cell_mode_t;

	// Control broadcast from the sequencer to every cell
	typedef struct packed {
		logic                 cmp;   // latch the compare result this cycle
		cell_mode_t           mode;
		logic [IDX_MAX_W-1:0] lo;
		logic [IDX_MAX_W-1:0] hi;
	} cell_ctl_t;

endpackage

// ===== hdl/okl_cell.sv =====
// One slot of the key list: stored key, equality compare and neighbor shift.
`timescale 1ns / 1ps

module okl_cell import okl_pkg::*; #(
	parameter int KEY_BITS = DEF_KEY_BITS,
	parameter int CNT_W    = 5,
	parameter int IDX      = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_ctl_t           ctl,
	input  logic [KEY_BITS-1:0] key_in,
	input  logic [KEY_BITS-1:0] left_key,
	input  logic [KEY_BITS-1:0] right_key,
	input  logic [CNT_W-1:0]    count,
	output logic [KEY_BITS-1:0] entry,
	output logic                match
);

	localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

	logic [KEY_BITS-1:0] entry_q;
	logic                match_q;
	logic                occupied;

	assign occupied = CNT_W'(IDX) < count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp) begin
			match_q <= occupied && (entry_q == key_in);
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.mode)
			CM_INS: begin
				if (MY_IDX == ctl.lo)
					entry_q <= key_in;
				else if (MY_IDX > ctl.lo && MY_IDX <= ctl.hi)
					entry_q <= left_key;
			end
			CM_DEL: begin
				if (MY_IDX >= ctl.lo)
					entry_q <= right_key;
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

// ===== hdl/ordered_key_list_engine.sv =====
// Top level of the ordered key list engine: sequencer, result register and cell row.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY unique keys, numbered from 0 at the top, held in a
// row of cells that each own one slot. A request beat carries opcode, key and
// offset: insert at offset / top / bottom, remove by offset or by key, find, or
// move a key to the top. Each request returns exactly one result beat with
// status, position and the count after the request. When a request is accepted
// every cell compares its slot against the key; then, in the execute state and
// once the output register is free, the sequencer decodes the match vector, the
// cells shift by one place toward or away from the top as the opcode needs, and
// the result is loaded into the output register. A stalled result holds the
// block in its execute state until the output register frees. The list is
// empty after reset; slot contents need no clearing since only slots below the
// count are ever compared.

module ordered_key_list_engine import okl_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int KEY_BITS = DEF_KEY_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [OP_W-1:0]      opcode,
	input  logic [KEY_W-1:0]     key,
	input  logic [OFS_W-1:0]     offset,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ST_W-1:0]      status,
	output logic [POS_W-1:0]     position,
	output logic [CNT_OUT_W-1:0] count
);

	// count spans 0..CAPACITY; compares against the 5-bit offset use the wider width
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > OFS_W) ? CNT_W : OFS_W;
	localparam int KIN_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

	localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);
	localparam logic [CMP_W-1:0] LAST    = CMP_W'(CAPACITY - 1);
	localparam logic [CMP_W-1:0] ONE     = CMP_W'(1);

	// Sequencer states
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                state_q;
	logic [CNT_W-1:0]    count_q;

	// request held through the execute cycle
	logic [OP_W-1:0]     op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [OFS_W-1:0]    ofs_q;

	// result register
	logic                out_valid_q;
	logic [ST_W-1:0]     status_q;
	logic [POS_W-1:0]    position_q;
	logic [CNT_OUT_W-1:0] cnt_out_q;

	logic                in_fire;
	logic                out_free;
	logic                exec_fire;

	// key reduced to KEY_BITS, zero extended where KEY_BITS exceeds the port
	logic [KEY_BITS-1:0] key_in;
	logic [KEY_BITS-1:0] cell_key;

	cell_ctl_t           ctl;

	logic [CAPACITY-1:0] match;
	logic [KEY_BITS-1:0] entry [CAPACITY];

	// decode of the execute cycle
	logic                found;
	logic [CMP_W-1:0]    fidx;
	logic [CMP_W-1:0]    cnt_ext;
	logic [CMP_W-1:0]    ofs_ext;
	logic [CMP_W-1:0]    at;
	logic [ST_W-1:0]     res_status;
	logic [CMP_W-1:0]    res_pos;
	logic [CMP_W-1:0]    res_cnt;
	cell_mode_t          res_mode;
	logic [CMP_W-1:0]    res_lo;
	logic [CMP_W-1:0]    res_hi;

	assign key_in    = KEY_BITS'(key[KIN_W-1:0]);
	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign exec_fire = (state_q == ST_EXEC) && out_free;

	// during the compare cycle the cells see the port key, afterwards the held one
	assign cell_key = in_fire ? key_in : key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= opcode;
			key_q <= key_in;
			ofs_q <= offset;
		end
	end

	// one-hot match (keys are unique) folded into a binary index
	always_comb begin
		fidx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match[i])
				fidx = fidx | CMP_W'(i);
		end
	end

	assign found   = |match;
	assign cnt_ext = CMP_W'(count_q);
	assign ofs_ext = CMP_W'(ofs_q);

	always_comb begin
		res_status = ST_OK;
		res_pos    = cnt_ext;
		res_cnt    = cnt_ext;
		res_mode   = CM_HOLD;
		res_lo     = '0;
		res_hi     = LAST;
		at         = '0;
		unique case (op_q) inside
			OP_INS_OFS, OP_INS_TOP, OP_INS_BOT: begin
				if (op_q == OP_INS_OFS)
					at = ofs_ext;
				else if (op_q == OP_INS_BOT)
					at = cnt_ext;
				if (at > cnt_ext) begin
					res_status = ST_RANGE;
				end else if (found) begin
					res_status = ST_DUP;
					res_pos    = fidx;
				end else if (cnt_ext >= CAP_CMP) begin
					res_status = ST_FULL;
				end else begin
					res_pos  = at;
					res_cnt  = cnt_ext + ONE;
					res_mode = CM_INS;
					res_lo   = at;
				end
			end
			OP_DEL_OFS: begin
				if (ofs_ext >= cnt_ext) begin
					res_status = ST_RANGE;
				end else begin
					res_pos  = ofs_ext;
					res_cnt  = cnt_ext - ONE;
					res_mode = CM_DEL;
					res_lo   = ofs_ext;
				end
			end
			OP_DEL_KEY: begin
				if (!found) begin
					res_status = ST_MISSING;
				end else begin
					res_pos  = fidx;
					res_cnt  = cnt_ext - ONE;
					res_mode = CM_DEL;
					res_lo   = fidx;
				end
			end
			OP_FIND: begin
				if (found)
					res_pos = fidx;
				else
					res_status = ST_MISSING;
			end
			OP_MTF: begin
				// rotate slots 0..fidx down by one and drop the key in at the top
				if (!found) begin
					res_status = ST_MISSING;
				end else begin
					res_pos  = '0;
					res_mode = CM_INS;
					res_lo   = '0;
					res_hi   = fidx;
				end
			end
			default: begin
				res_status = ST_RANGE;
			end
		endcase
	end

	always_comb begin
		ctl.cmp  = in_fire;
		ctl.mode = exec_fire ? res_mode : CM_HOLD;
		ctl.lo   = IDX_MAX_W'(res_lo);
		ctl.hi   = IDX_MAX_W'(res_hi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec_fire) begin
				count_q     <= CNT_W'(res_cnt);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			status_q   <= res_status;
			position_q <= POS_W'(res_pos);
			cnt_out_q  <= CNT_OUT_W'(res_cnt);
		end
	end

	// Cell row: each slot hands its key to the neighbor below or above
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [KEY_BITS-1:0] left_key;
		logic [KEY_BITS-1:0] right_key;

		if (g == 0) begin : g_top
			assign left_key = cell_key;
		end else begin : g_mid
			assign left_key = entry[g-1];
		end

		if (g == CAPACITY - 1) begin : g_bot
			assign right_key = entry[g];
		end else begin : g_up
			assign right_key = entry[g+1];
		end

		okl_cell #(
			.KEY_BITS (KEY_BITS),
			.CNT_W    (CNT_W),
			.IDX      (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.key_in    (cell_key),
			.left_key  (left_key),
			.right_key (right_key),
			.count     (count_q),
			.entry     (entry[g]),
			.match     (match[g])
		);
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = position_q;
	assign count     = cnt_out_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CAP_CMP)
		else $error("list count above capacity");

	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("key matched in more than one slot");

	a_count_only_on_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!exec_fire |=> $stable(count_q))
		else $error("count moved outside an execute cycle");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("result beat without an executed request");

	a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_EXEC))
		else $error("accepted request did not reach execute");

endmodule

// ===== bench/tb_ordered_key_list_engine.sv =====
// Self-checking bench for the ordered key list engine: random and corner requests, predicted results.
`timescale 1ns / 1ps

module tb_ordered_key_list_engine;
	import okl_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int LIST_CAP    = DEF_CAPACITY;
	localparam int POOL_SIZE   = 24;     // a bit more keys than slots, so inserts hit both dup and full
	localparam int HOLD_CYCLES = 80;     // long receiver hold-off, well past the block's buffering
	localparam int TAIL_CYCLES = 20;     // quiet time after the last result to catch stray beats
	localparam int IDLE_LIMIT  = 2000;   // cycles with no beat on either channel before giving up
	localparam int PRINT_CAP   = 40;
	localparam int RANDOM_REQS = 1330;

	// Opcode seven has no meaning; the block must answer it with a range error
	localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

	typedef enum logic [1:0] {BEAT_REQ, BEAT_DRAIN, BEAT_RX_HOLD} beat_kind_t;
	typedef enum logic [1:0] {MIX_FILL, MIX_CHURN, MIX_EMPTY} mix_t;

	// One entry of the send queue: a request beat, or a marker that steers the sender
	typedef struct {
		beat_kind_t       kind;
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] k;
		logic [OFS_W-1:0] ofs;
		int               gap;    // idle cycles the sender waits before offering this beat
	} req_beat_t;

	typedef struct {
		logic [ST_W-1:0]      status;
		logic [POS_W-1:0]     position;
		logic [CNT_OUT_W-1:0] count;
	} list_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [OP_W-1:0]      opcode    = '0;
	logic [KEY_W-1:0]     key       = '0;
	logic [OFS_W-1:0]     offset    = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [ST_W-1:0]      status;
	logic [POS_W-1:0]     position;
	logic [CNT_OUT_W-1:0] count;

	ordered_key_list_engine #(
		.CAPACITY(LIST_CAP),
		.KEY_BITS(KEY_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.key(key),
		.offset(offset),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.position(position),
		.count(count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin : reset_seq
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Shadow list: top of the list is slot 0, only slots below list_len are live
	// ------------------------------------------------------------------
	logic [KEY_W-1:0] list_keys [LIST_CAP];
	int               list_len = 0;

	function automatic int key_index(logic [KEY_W-1:0] k);
		for (int i = 0; i < list_len; i++)
			if (list_keys[i] == k)
				return i;
		return list_len;
	endfunction

	// Insert ahead of slot at. Order of checks matters: past-end, then duplicate, then full.
	function automatic list_result_t place_key(logic [KEY_W-1:0] k, int at);
		list_result_t r;
		int found;
		found = key_index(k);
		r.status = ST_OK;
		r.position = POS_W'(at);
		if (at > list_len) begin
			r.status = ST_RANGE;
			r.position = POS_W'(list_len);
		end else if (found != list_len) begin
			r.status = ST_DUP;
			r.position = POS_W'(found);
		end else if (list_len >= LIST_CAP) begin
			r.status = ST_FULL;
			r.position = POS_W'(list_len);
		end else begin
			for (int i = list_len; i > at; i--)
				list_keys[i] = list_keys[i - 1];
			list_keys[at] = k;
			list_len++;
		end
		r.count = CNT_OUT_W'(list_len);
		return r;
	endfunction

	// Close the hole at slot at; stops at the last live slot
	function automatic void drop_slot(int at);
		for (int i = at; i + 1 < list_len; i++)
			list_keys[i] = list_keys[i + 1];
		list_len--;
	endfunction

	// Applies one accepted request to the shadow list and returns the result beat it must produce
	function automatic list_result_t apply_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
			logic [OFS_W-1:0] ofs);
		list_result_t r;
		int idx;
		int at;
		at = int'(ofs);
		r.status = ST_OK;
		r.position = POS_W'(list_len);
		case (op)
			OP_INS_OFS: r = place_key(k, at);
			OP_INS_TOP: r = place_key(k, 0);
			OP_INS_BOT: r = place_key(k, list_len);
			OP_DEL_OFS: begin
				if (at >= list_len) begin
					r.status = ST_RANGE;
				end else begin
					drop_slot(at);
					r.position = POS_W'(at);
				end
			end
			OP_DEL_KEY: begin
				idx = key_index(k);
				if (idx == list_len) begin
					r.status = ST_MISSING;
				end else begin
					drop_slot(idx);
					r.position = POS_W'(idx);
				end
			end
			OP_FIND: begin
				idx = key_index(k);
				r.position = POS_W'(idx);
				if (idx == list_len)
					r.status = ST_MISSING;
			end
			OP_MTF: begin
				idx = key_index(k);
				if (idx == list_len) begin
					r.status = ST_MISSING;
				end else begin
					// pull it out and put it back on top; always fits since a slot was just freed
					drop_slot(idx);
					void'(place_key(k, 0));
					r.position = '0;
				end
			end
			default: r.status = ST_RANGE;
		endcase
		r.count = CNT_OUT_W'(list_len);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Shared bookkeeping
	// ------------------------------------------------------------------
	req_beat_t    request_q [$];
	list_result_t pending_results [$];
	int           fail_cnt  = 0;
	int           rx_cnt    = 0;
	int           hold_reqs = 0;   // bumped by the sender, followed by the receiver
	int           tx_wait   = 0;

	task automatic report_mismatch(string what, int got, int want);
		if (fail_cnt < PRINT_CAP)
			$display("%0t ns: result %0d: %s got %0d, want %0d", $time, rx_cnt, what, got, want);
		fail_cnt++;
	endtask

	// Idle draw for either side: mostly a uniform random wait, with occasional runs of back-to-back beats
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 8);
	endfunction

	// ------------------------------------------------------------------
	// Request driver. The payload of a stalled beat stays put; valid only drops
	// when the queue says so, never because of stall.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : req_driver
		bit settled;
		if (arst_n) begin
			if (in_valid && !in_stall)
				pending_results.push_back(apply_request(opcode, key, offset));
			if (!in_valid || !in_stall) begin
				settled = 1'b0;
				while (!settled) begin
					if (request_q.size() == 0) begin
						in_valid <= 1'b0;
						settled = 1'b1;
					end else if (request_q[0].kind == BEAT_DRAIN) begin
						// pause until every result owed so far has come back
						if (pending_results.size() == 0) begin
							request_q.delete(0);
						end else begin
							in_valid <= 1'b0;
							settled = 1'b1;
						end
					end else if (request_q[0].kind == BEAT_RX_HOLD) begin
						hold_reqs++;
						request_q.delete(0);
					end else if (tx_wait < request_q[0].gap) begin
						tx_wait++;
						in_valid <= 1'b0;
						settled = 1'b1;
					end else begin
						opcode   <= request_q[0].op;
						key      <= request_q[0].k;
						offset   <= request_q[0].ofs;
						in_valid <= 1'b1;
						tx_wait = 0;
						request_q.delete(0);
						settled = 1'b1;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor and stall generator
	// ------------------------------------------------------------------
	int rx_wait   = 0;
	int rx_calm   = 0;
	int hold_left = 0;
	int hold_seen = 0;

	always @(posedge clk) begin : result_monitor
		list_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected beat, status", int'(status), -1);
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status)
						report_mismatch("status", int'(status), int'(want.status));
					if (position !== want.position)
						report_mismatch("position", int'(position), int'(want.position));
					if (count !== want.count)
						report_mismatch("count", int'(count), int'(want.count));
				end
				rx_cnt++;
				rx_wait = draw_wait(rx_calm);
			end
			// the long hold-off is counted here, independent of what the sender does
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: a run that stops moving beats is a failure
	// ------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin : watchdog
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int               tx_calm = 0;

	task automatic push_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, int ofs);
		req_beat_t b;
		b.kind = BEAT_REQ;
		b.op   = op;
		b.k    = k;
		b.ofs  = OFS_W'(ofs);
		b.gap  = draw_wait(tx_calm);
		request_q.push_back(b);
	endtask

	task automatic push_marker(beat_kind_t kind);
		req_beat_t b;
		b.kind = kind;
		b.op   = OP_FIND;
		b.k    = '0;
		b.ofs  = '0;
		b.gap  = 0;
		request_q.push_back(b);
	endtask

	// Mostly keys from a small pool so finds, moves and dups hit; now and then a fresh one
	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return key_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	// Insert share sets where the list drifts: toward full, around the middle, or toward empty
	function automatic logic [OP_W-1:0] pick_op(mix_t mix);
		int ins_pct;
		int r;
		ins_pct = (mix == MIX_FILL) ? 65 : (mix == MIX_CHURN) ? 40 : 20;
		r = $urandom_range(0, 99);
		if (r == 99)
			return OP_SPARE;
		if (r < ins_pct) begin
			case ($urandom_range(0, 2))
				0: return OP_INS_OFS;
				1: return OP_INS_TOP;
				default: return OP_INS_BOT;
			endcase
		end
		case ($urandom_range(0, 3))
			0: return OP_DEL_OFS;
			1: return OP_DEL_KEY;
			2: return OP_FIND;
			default: return OP_MTF;
		endcase
	endfunction

	// Near the top and inside the list most of the time, the whole 5-bit range sometimes
	function automatic int pick_offset();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 31);
			1, 2, 3: return $urandom_range(0, 4);
			default: return $urandom_range(0, 17);
		endcase
	endfunction

	initial begin : stimulus
		int n_req;
		int burst;
		mix_t mix;
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 32'hA5A5_A5A5;
		key_pool[3] = 32'h5A5A_5A5A;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		// Directed corners, starting from the empty list
		push_req(OP_FIND,    key_pool[0], 0);    // find on empty: missing, position 0
		push_req(OP_DEL_OFS, key_pool[0], 0);    // remove at offset on empty
		push_req(OP_DEL_KEY, key_pool[1], 0);    // remove of missing key
		push_req(OP_MTF,     key_pool[1], 0);    // move of missing key
		push_req(OP_INS_OFS, key_pool[2], 1);    // insert past the end
		push_req(OP_INS_TOP, key_pool[0], 0);
		push_req(OP_INS_BOT, key_pool[1], 31);   // offset ignored for bottom insert
		push_req(OP_INS_OFS, key_pool[2], 1);    // insert in the middle
		push_req(OP_INS_OFS, key_pool[3], 3);    // insert right at the count
		push_req(OP_INS_OFS, key_pool[0], 2);    // duplicate: reports where it already is
		push_req(OP_INS_OFS, key_pool[1], 31);   // past end wins over duplicate
		push_req(OP_FIND,    key_pool[2], 0);
		push_req(OP_MTF,     key_pool[3], 0);    // move from the bottom to the top
		push_req(OP_MTF,     key_pool[3], 0);    // move of the key already on top
		push_req(OP_DEL_KEY, key_pool[0], 0);
		push_req(OP_DEL_OFS, key_pool[0], 31);   // remove at offset far out of range
		push_req(OP_DEL_OFS, key_pool[0], 2);    // remove the last live entry
		push_req(OP_SPARE,   key_pool[2], 0);    // unused opcode
		push_marker(BEAT_DRAIN);

		// Random phases; every fourth one fills the list so the full case comes up often
		n_req = 0;
		for (int ph = 0; n_req < RANDOM_REQS; ph++) begin
			mix = mix_t'($urandom_range(0, 2));
			if (ph % 4 == 0)
				mix = MIX_FILL;
			if (ph == 3) begin
				// receiver holds off while the sender streams back to back, so the
				// block backs up and has to stall its input
				push_marker(BEAT_RX_HOLD);
				tx_calm = 30;
			end
			burst = $urandom_range(30, 90);
			for (int i = 0; i < burst; i++)
				push_req(pick_op(mix), pick_key(), pick_offset());
			n_req += burst;
			if (ph == 5 || $urandom_range(0, 2) == 0)
				push_marker(BEAT_DRAIN);
		end

		while (request_q.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
